@@ rtl/crc16s_pkg.sv @@
package crc16s_pkg;

   localparam logic [1:0] KIND_CRC_CREATE = 2'd0;
   localparam logic [1:0] KIND_SUM_CREATE = 2'd1;
   localparam logic [1:0] KIND_CRC_CHECK  = 2'd2;

   localparam logic CSR_KIND = 1'b0;
   localparam logic CSR_POLY = 1'b1;

   localparam logic [1:0]  KIND_RESET = KIND_CRC_CREATE;
   localparam logic [15:0] POLY_RESET = 16'h1021;
   localparam logic [15:0] CHECK_ZERO = 16'h0000;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] poly;
   } cfg_type;

   typedef struct packed {
      logic [15:0] value;
      logic        mismatch;
   } result_type;

   function automatic logic [15:0] crc_fold_byte(input logic [15:0] crc,
                                                 input logic [7:0]  data,
                                                 input logic [15:0] poly);
      logic [15:0] acc;
      acc = crc ^ {data, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (acc[15]) begin
            acc = {acc[14:0], 1'b0} ^ poly;
         end else begin
            acc = {acc[14:0], 1'b0};
         end
      end
      return acc;
   endfunction

endpackage

@@ rtl/crc16s_csr.sv @@
module crc16s_csr (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   input  logic                 csr_index,
   input  logic [15:0]          csr_wdata,
   output crc16s_pkg::cfg_type  cfg
);

   crc16s_pkg::cfg_type cfg_ff;
   crc16s_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            crc16s_pkg::CSR_KIND: cfg_in.kind = csr_wdata[1:0];
            crc16s_pkg::CSR_POLY: cfg_in.poly = csr_wdata;
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.kind <= crc16s_pkg::KIND_RESET;
         cfg_ff.poly <= crc16s_pkg::POLY_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ rtl/crc16s_update.sv @@
module crc16s_update (
   input  crc16s_pkg::cfg_type     cfg,
   input  logic [15:0]             running,
   input  logic [7:0]              data_byte,
   input  logic                    last_byte,
   input  logic [15:0]             received_checksum,
   output logic [15:0]             running_next,
   output crc16s_pkg::result_type  result
);

   logic [15:0] folded;

   always_comb begin
      case (cfg.kind)
         crc16s_pkg::KIND_CRC_CREATE,
         crc16s_pkg::KIND_CRC_CHECK:
            folded = crc16s_pkg::crc_fold_byte(running, data_byte, cfg.poly);
         crc16s_pkg::KIND_SUM_CREATE:
            folded = running + {8'h00, data_byte};
         default:
            folded = running;
      endcase
   end

   always_comb begin
      result.value    = crc16s_pkg::CHECK_ZERO;
      result.mismatch = 1'b0;
      case (cfg.kind)
         crc16s_pkg::KIND_CRC_CREATE,
         crc16s_pkg::KIND_SUM_CREATE: begin
            result.value = folded;
         end
         crc16s_pkg::KIND_CRC_CHECK: begin
            result.value    = folded;
            result.mismatch = (folded != received_checksum);
         end
         default: begin
            result.value    = crc16s_pkg::CHECK_ZERO;
            result.mismatch = 1'b0;
         end
      endcase
   end

   assign running_next = last_byte ? crc16s_pkg::CHECK_ZERO : folded;

endmodule

@@ rtl/crc16_or_sum16_checksum.sv @@
// An accepted last byte goes via the input register to the result register.
// Throughput: one byte per cycle; the 8-bit CRC step is unrolled between the
// input register and the running value / result register.
// A stalled result holds back only a last byte waiting behind it.
// Reset (synchronous) clears the running value, the valid flags and loads
// kind 0 (create CRC16) and polynomial 0x1021.
module crc16_or_sum16_checksum (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   input  logic [15:0] req_received_checksum,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_checksum_value,
   output logic        rsp_match_status,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);

   crc16s_pkg::cfg_type    cfg;
   crc16s_pkg::result_type result;

   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_byte_ff;
   logic        in_last_ff;
   logic [15:0] in_received_ff;
   logic [15:0] running_ff, running_in, running_next;
   logic        out_valid_ff, out_valid_in;
   logic [15:0] out_value_ff;
   logic        out_mismatch_ff;
   logic        advance, accept, out_free;

   crc16s_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   crc16s_update u_update (
      .cfg               (cfg),
      .running           (running_ff),
      .data_byte         (in_byte_ff),
      .last_byte         (in_last_ff),
      .received_checksum (in_received_ff),
      .running_next      (running_next),
      .result            (result)
   );

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && (!in_last_ff || out_free);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   assign in_valid_in  = accept || (in_valid_ff && !advance);
   assign running_in   = advance ? running_next : running_ff;
   assign out_valid_in = (advance && in_last_ff) || (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         running_ff   <= crc16s_pkg::CHECK_ZERO;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         running_ff   <= running_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff     <= req_data_byte;
         in_last_ff     <= req_last_byte;
         in_received_ff <= req_received_checksum;
      end
      if (advance && in_last_ff) begin
         out_value_ff    <= result.value;
         out_mismatch_ff <= result.mismatch;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_checksum_value = out_value_ff;
   assign rsp_match_status   = out_mismatch_ff;
   assign csr_ready          = 1'b1;

endmodule

@@ rtl/crc16s_checker.sv @@
module crc16s_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        req_last_byte,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [15:0] rsp_checksum_value,
   input logic        rsp_match_status
);

   // no result word straight out of reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word valid after reset");

   // a fresh result word must trace back to an accepted last byte
   a_latency: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall && req_last_byte, 2))
      else $error("result word without a last byte two cycles before");

   // hold a stalled result word
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_checksum_value)
                                 && $stable(rsp_match_status))
      else $error("stalled result word changed");

endmodule

bind crc16_or_sum16_checksum crc16s_checker u_crc16s_checker (.*);
